### rtl/sbsd_pkg.sv
`default_nettype none
package sbsd_pkg;

	localparam int COUNT_BITS = 10;
	localparam int TIMER_BITS = 20;
	localparam int CMP_BITS   = (COUNT_BITS > 10) ? COUNT_BITS : 10;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 20;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PWM_PERIOD       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TICKS   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DOOR_PHASE_TICKS = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_RECYCLABLE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_HAZARDOUS  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_KITCHEN    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_OTHER      = 3'd6;

	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_N = 8'h4E;
	localparam logic [7:0] CHAR_R = 8'h52;
	localparam logic [7:0] CHAR_H = 8'h48;
	localparam logic [7:0] CHAR_K = 8'h4B;
	localparam logic [7:0] CHAR_O = 8'h4F;

	localparam logic [9:0]  RST_PWM_PERIOD       = 10'd400;
	localparam logic [15:0] RST_DEBOUNCE_TICKS   = 16'd1000;
	localparam logic [19:0] RST_DOOR_PHASE_TICKS = 20'd20000;
	localparam logic [9:0]  RST_WIDTH_RECYCLABLE = 10'd8;
	localparam logic [9:0]  RST_WIDTH_HAZARDOUS  = 10'd19;
	localparam logic [9:0]  RST_WIDTH_KITCHEN    = 10'd29;
	localparam logic [9:0]  RST_WIDTH_OTHER      = 10'd36;
	localparam logic [9:0]  RST_PULSE_WIDTH      = 10'd10;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_OPEN  = 4'b0010,
		MODE_HOLD  = 4'b0100,
		MODE_CLOSE = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [3:0] sensor_lines;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       servo_level;
		logic       motor_enable;
		logic       dir_open;
		logic       dir_close;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       bin_full;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/sbsd_core.sv
`default_nettype none
module sbsd_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [sbsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [sbsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                step,
	input  sbsd_pkg::in_item_t                 item,
	output sbsd_pkg::out_item_t                result
);
	import sbsd_pkg::*;

	// configuration
	logic [9:0]  pwm_period_q;
	logic [15:0] debounce_ticks_q;
	logic [19:0] door_phase_ticks_q;
	logic [9:0]  width_r_q, width_h_q, width_k_q, width_o_q;

	// tick state
	logic [COUNT_BITS-1:0] frame_count_q, frame_count_d;
	logic [9:0]            pulse_width_q, pulse_width_d;
	mode_t                 mode_q, mode_d;
	logic [TIMER_BITS-1:0] phase_timer_q, phase_timer_d;
	logic                  last_raw_q, last_raw_d;
	logic                  full_q, full_d;
	logic                  primed_q;
	logic                  pend_valid_q, pend_valid_d;
	logic [7:0]            pend_byte_q, pend_byte_d;
	logic                  en_q, en_d, open_q, open_d, close_q, close_d;
	logic                  deb_busy_q, deb_busy_d;
	logic [15:0]           deb_left_q, deb_left_d;

	logic [COUNT_BITS-1:0] frame_inc;
	logic                  level;
	logic                  raw;
	logic                  resolve_now;
	logic [7:0]            tx;
	logic [TIMER_BITS-1:0] phase_len;
	logic [TIMER_BITS-1:0] phase_cfg;
	logic                  class_hit;
	logic [9:0]            class_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q       <= RST_PWM_PERIOD;
			debounce_ticks_q   <= RST_DEBOUNCE_TICKS;
			door_phase_ticks_q <= RST_DOOR_PHASE_TICKS;
			width_r_q          <= RST_WIDTH_RECYCLABLE;
			width_h_q          <= RST_WIDTH_HAZARDOUS;
			width_k_q          <= RST_WIDTH_KITCHEN;
			width_o_q          <= RST_WIDTH_OTHER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PWM_PERIOD:       pwm_period_q       <= cfg_data[9:0];
				CFG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_data[15:0];
				CFG_DOOR_PHASE_TICKS: door_phase_ticks_q <= cfg_data[19:0];
				CFG_WIDTH_RECYCLABLE: width_r_q          <= cfg_data[9:0];
				CFG_WIDTH_HAZARDOUS:  width_h_q          <= cfg_data[9:0];
				CFG_WIDTH_KITCHEN:    width_k_q          <= cfg_data[9:0];
				CFG_WIDTH_OTHER:      width_o_q          <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign phase_cfg = TIMER_BITS'(door_phase_ticks_q);
	assign phase_len = (phase_cfg == '0) ? '0 : phase_cfg - 1'b1;

	// class decode of the pending byte
	always_comb begin
		class_hit   = 1'b1;
		class_width = width_r_q;
		unique case (pend_byte_d)
			CHAR_R:  class_width = width_r_q;
			CHAR_H:  class_width = width_h_q;
			CHAR_K:  class_width = width_k_q;
			CHAR_O:  class_width = width_o_q;
			default: class_hit   = 1'b0;
		endcase
	end

	always_comb begin
		// servo frame
		frame_inc     = frame_count_q + 1'b1;
		level         = CMP_BITS'(frame_inc) <= CMP_BITS'(pulse_width_q);
		frame_count_d = frame_inc;
		if (CMP_BITS'(frame_inc) >= CMP_BITS'(pwm_period_q)) begin
			frame_count_d = '0;
			level         = 1'b1;
		end

		// byte latch, newest wins
		pend_valid_d = pend_valid_q;
		pend_byte_d  = pend_byte_q;
		if (item.rx_valid) begin
			pend_valid_d = 1'b1;
			pend_byte_d  = item.rx_byte;
		end

		raw        = item.sensor_lines != 4'hF;
		last_raw_d = primed_q ? last_raw_q : raw;

		pulse_width_d = pulse_width_q;
		mode_d        = mode_q;
		phase_timer_d = phase_timer_q;
		full_d        = full_q;
		en_d          = en_q;
		open_d        = open_q;
		close_d       = close_q;
		deb_busy_d    = deb_busy_q;
		deb_left_d    = deb_left_q;
		resolve_now   = 1'b0;
		tx            = '0;

		priority if (mode_q != MODE_IDLE) begin
			if (phase_timer_q != '0) begin
				phase_timer_d = phase_timer_q - 1'b1;
			end else begin
				unique case (mode_q)
					MODE_OPEN: begin
						mode_d        = MODE_HOLD;
						en_d          = 1'b0;
						phase_timer_d = phase_len;
					end
					MODE_HOLD: begin
						mode_d        = MODE_CLOSE;
						en_d          = 1'b1;
						open_d        = 1'b0;
						close_d       = 1'b1;
						phase_timer_d = phase_len;
					end
					default: begin
						mode_d        = MODE_IDLE;
						en_d          = 1'b0;
						phase_timer_d = '0;
					end
				endcase
			end
		end else if (deb_busy_q) begin
			deb_left_d  = deb_left_q - 1'b1;
			resolve_now = deb_left_d == '0;
		end else if (raw != last_raw_d) begin
			deb_busy_d  = 1'b1;
			deb_left_d  = debounce_ticks_q;
			resolve_now = debounce_ticks_q == '0;
		end else if (pend_valid_d) begin
			pend_valid_d = 1'b0;
			if (class_hit) begin
				if (full_q) begin
					en_d = 1'b0;
					tx   = CHAR_F;
				end else begin
					pulse_width_d = class_width;
					mode_d        = MODE_OPEN;
					en_d          = 1'b1;
					open_d        = 1'b1;
					close_d       = 1'b0;
					phase_timer_d = phase_len;
				end
			end
		end else begin
			// nothing pending, state holds
		end

		// confirm or drop the sensor change
		if (resolve_now) begin
			deb_busy_d = 1'b0;
			if (raw != last_raw_d) begin
				last_raw_d = raw;
				if (raw && !full_q) begin
					full_d = 1'b1;
					en_d   = 1'b0;
					tx     = CHAR_F;
				end else if (!raw && full_q) begin
					full_d = 1'b0;
					tx     = CHAR_N;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			pulse_width_q <= RST_PULSE_WIDTH;
			mode_q        <= MODE_IDLE;
			phase_timer_q <= '0;
			last_raw_q    <= 1'b0;
			full_q        <= 1'b0;
			primed_q      <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_byte_q   <= '0;
			en_q          <= 1'b0;
			open_q        <= 1'b0;
			close_q       <= 1'b0;
			deb_busy_q    <= 1'b0;
			deb_left_q    <= '0;
		end else if (step) begin
			frame_count_q <= frame_count_d;
			pulse_width_q <= pulse_width_d;
			mode_q        <= mode_d;
			phase_timer_q <= phase_timer_d;
			last_raw_q    <= last_raw_d;
			full_q        <= full_d;
			primed_q      <= 1'b1;
			pend_valid_q  <= pend_valid_d;
			pend_byte_q   <= pend_byte_d;
			en_q          <= en_d;
			open_q        <= open_d;
			close_q       <= close_d;
			deb_busy_q    <= deb_busy_d;
			deb_left_q    <= deb_left_d;
		end
	end

	assign result.servo_level  = level;
	assign result.motor_enable = en_d;
	assign result.dir_open     = open_d;
	assign result.dir_close    = close_d;
	assign result.tx_valid     = tx != '0;
	assign result.tx_byte      = tx;
	assign result.bin_full     = full_d;

	a_idle_motor_off: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> !en_q)
		else $error("motor enabled while door idle");
	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(open_q && close_q))
		else $error("both direction lines high");
	a_debounce_idle: assert property (@(posedge clk) disable iff (!arst_n)
		deb_busy_q |-> (mode_q == MODE_IDLE))
		else $error("debounce running during door sequence");

endmodule
`default_nettype wire

### rtl/sorting_bin_servo_door_controller.sv
// a result item is registered when its tick item is accepted, into the skid if the head stalls
// throughput: one tick item per cycle while the skid entry is free;
// the tick state updates in a single pass; a two-entry output stage
// (result register plus skid) absorbs one item while the result side stalls
// reset (arst_n low, asynchronous): all but the payload registers take defaults,
// door idle, motor lines low, no pending byte, sensors not yet sampled
`default_nettype none
module sorting_bin_servo_door_controller (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [sbsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [sbsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                item_valid,
	output logic                               item_stall,
	input  sbsd_pkg::in_item_t                 item,
	output logic                               result_valid,
	input  wire                                result_stall,
	output sbsd_pkg::out_item_t                result
);
	import sbsd_pkg::*;

	out_item_t step_result;
	out_item_t result_q;
	out_item_t skid_q;
	logic      result_valid_q;
	logic      skid_valid_q;
	logic      push;
	logic      pop;

	// item taken only while the skid entry is free
	assign item_stall = skid_valid_q;
	assign push       = item_valid && !skid_valid_q;
	assign pop        = result_valid_q && !result_stall;

	// all tick processing: servo frame, debounce, command and door sequence
	sbsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (push),
		.item      (item),
		.result    (step_result)
	);

	// control of the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (!result_valid_q || pop) begin
			// head free or leaving: refill from skid first, then from the core
			if (skid_valid_q) begin
				result_valid_q <= 1'b1;
				skid_valid_q   <= 1'b0;
			end else begin
				result_valid_q <= push;
			end
		end else if (push) begin
			// head held by stall: park the new item
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the output stage, no reset needed
	always_ff @(posedge clk) begin
		if (!result_valid_q || pop) begin
			result_q <= skid_valid_q ? skid_q : step_result;
		end else if (push) begin
			skid_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// the skid entry is only ever filled behind a waiting head
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid entry holds an item with no head item");
	// a stalled result item stays put
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result item changed or dropped");
	// a parked item waits until the head moves
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |=> skid_valid_q)
		else $error("skid item lost while head stalled");

endmodule
`default_nettype wire

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsd_pkg::*;

	// cycles with neither side moving an item before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;
	// tx_byte value on ticks that send nothing
	localparam logic [7:0] NO_BYTE = 8'h00;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      item_valid;
	logic                      item_stall;
	in_item_t                  item;
	logic                      result_valid;
	logic                      result_stall;
	out_item_t                 result;

	sorting_bin_servo_door_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// outputs predicted for accepted ticks, oldest first
	out_item_t predicted_outputs[$];
	int        mismatch_count;
	int        hold_cycles;
	int        idle_cycles;
	// set for stretches where neither side idles
	bit        calm;
	// sensor pattern the random traffic currently holds
	logic [3:0] steady_sensors;

	// shadow copy of the configuration registers
	logic [9:0]            cfg_period;
	logic [15:0]           cfg_debounce;
	logic [19:0]           cfg_phase;
	logic [9:0]            cfg_w_r, cfg_w_h, cfg_w_k, cfg_w_o;

	// shadow copy of the controller state
	logic [COUNT_BITS-1:0] p_frame;
	logic [9:0]            p_width;
	mode_t                 p_mode;
	logic [TIMER_BITS-1:0] p_timer;
	logic                  p_last_raw, p_full, p_primed, p_pend_v;
	logic [7:0]            p_pend_b;
	logic                  p_en, p_open, p_close;
	logic                  p_deb_busy;
	logic [15:0]           p_deb_left;

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic reset_predictor();
		cfg_period   = RST_PWM_PERIOD;
		cfg_debounce = RST_DEBOUNCE_TICKS;
		cfg_phase    = RST_DOOR_PHASE_TICKS;
		cfg_w_r      = RST_WIDTH_RECYCLABLE;
		cfg_w_h      = RST_WIDTH_HAZARDOUS;
		cfg_w_k      = RST_WIDTH_KITCHEN;
		cfg_w_o      = RST_WIDTH_OTHER;
		p_frame      = '0;
		p_width      = RST_PULSE_WIDTH;
		p_mode       = MODE_IDLE;
		p_timer      = '0;
		p_last_raw   = 1'b0;
		p_full       = 1'b0;
		p_primed     = 1'b0;
		p_pend_v     = 1'b0;
		p_pend_b     = 8'h00;
		p_en         = 1'b0;
		p_open       = 1'b0;
		p_close      = 1'b0;
		p_deb_busy   = 1'b0;
		p_deb_left   = '0;
	endtask

	// each door phase counts the tick that enters it, a length of 0 acts as 1
	function automatic logic [TIMER_BITS-1:0] phase_reload();
		logic [TIMER_BITS-1:0] p;
		p = TIMER_BITS'(cfg_phase);
		return (p == '0) ? '0 : p - 1'b1;
	endfunction

	// end of a debounce window: accept the change only if the sample still differs
	function automatic logic [7:0] settle_change(input logic raw);
		p_deb_busy = 1'b0;
		if (raw == p_last_raw)
			return NO_BYTE;
		p_last_raw = raw;
		if (raw && !p_full) begin
			p_full = 1'b1;
			p_en   = 1'b0;
			return CHAR_F;
		end
		if (!raw && p_full) begin
			p_full = 1'b0;
			return CHAR_N;
		end
		return NO_BYTE;
	endfunction

	// one 50 us tick: servo frame, byte latch, sensor sample, then one action
	function automatic out_item_t predict_tick(input in_item_t it);
		out_item_t  r;
		logic       raw;
		logic       lvl;
		logic       cls;
		logic [7:0] tx;
		logic [9:0] w;
		tx = NO_BYTE;
		w  = '0;
		p_frame = p_frame + 1'b1;
		lvl = (p_frame <= p_width);
		if (p_frame >= cfg_period) begin
			p_frame = '0;
			lvl     = 1'b1;
		end
		if (it.rx_valid) begin
			p_pend_b = it.rx_byte;
			p_pend_v = 1'b1;
		end
		raw = (it.sensor_lines != 4'hF);
		// first sample after reset only primes the stored sensor state
		if (!p_primed) begin
			p_last_raw = raw;
			p_primed   = 1'b1;
		end
		if (p_mode != MODE_IDLE) begin
			if (p_timer != '0) begin
				p_timer = p_timer - 1'b1;
			end else begin
				case (p_mode)
					MODE_OPEN: begin
						p_mode  = MODE_HOLD;
						p_en    = 1'b0;
						p_timer = phase_reload();
					end
					MODE_HOLD: begin
						p_mode  = MODE_CLOSE;
						p_en    = 1'b1;
						p_open  = 1'b0;
						p_close = 1'b1;
						p_timer = phase_reload();
					end
					default: begin
						// direction lines keep their levels after close
						p_mode  = MODE_IDLE;
						p_en    = 1'b0;
						p_timer = '0;
					end
				endcase
			end
		end else if (p_deb_busy) begin
			p_deb_left = p_deb_left - 1'b1;
			if (p_deb_left == '0)
				tx = settle_change(raw);
		end else if (raw != p_last_raw) begin
			p_deb_busy = 1'b1;
			p_deb_left = cfg_debounce;
			if (p_deb_left == '0)
				tx = settle_change(raw);
		end else if (p_pend_v) begin
			p_pend_v = 1'b0;
			cls = 1'b1;
			case (p_pend_b)
				CHAR_R:  w = cfg_w_r;
				CHAR_H:  w = cfg_w_h;
				CHAR_K:  w = cfg_w_k;
				CHAR_O:  w = cfg_w_o;
				default: cls = 1'b0;
			endcase
			if (cls) begin
				if (p_full) begin
					// refused while full: motor off and full status resent
					p_en = 1'b0;
					tx   = CHAR_F;
				end else begin
					p_width = w;
					p_mode  = MODE_OPEN;
					p_en    = 1'b1;
					p_open  = 1'b1;
					p_close = 1'b0;
					p_timer = phase_reload();
				end
			end
		end
		r.servo_level  = lvl;
		r.motor_enable = p_en;
		r.dir_open     = p_open;
		r.dir_close    = p_close;
		r.tx_valid     = (tx != NO_BYTE);
		r.tx_byte      = tx;
		r.bin_full     = p_full;
		return r;
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic in_item_t tick_of(input logic [3:0] s, input logic v,
			input logic [7:0] b);
		in_item_t it;
		it.sensor_lines = s;
		it.rx_valid     = v;
		it.rx_byte      = b;
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// send one tick item, with a random gap in front, and record its prediction
	task automatic send_tick(input in_item_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			if (item_valid)
				item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predicted_outputs.push_back(predict_tick(it));
	endtask

	// stop sending and wait for every predicted output plus the output stage
	task automatic drain();
		if (item_valid)
			item_valid <= 1'b0;
		do @(posedge clk); while (predicted_outputs.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PWM_PERIOD:       cfg_period   = data[9:0];
			CFG_DEBOUNCE_TICKS:   cfg_debounce = data[15:0];
			CFG_DOOR_PHASE_TICKS: cfg_phase    = data[19:0];
			CFG_WIDTH_RECYCLABLE: cfg_w_r      = data[9:0];
			CFG_WIDTH_HAZARDOUS:  cfg_w_h      = data[9:0];
			CFG_WIDTH_KITCHEN:    cfg_w_k      = data[9:0];
			CFG_WIDTH_OTHER:      cfg_w_o      = data[9:0];
			default: ;
		endcase
	endtask

	// rewrite every register, only with nothing in flight
	task automatic configure(input logic [9:0] period, input logic [15:0] debounce,
			input logic [19:0] phase, input logic [9:0] w_r, input logic [9:0] w_h,
			input logic [9:0] w_k, input logic [9:0] w_o);
		drain();
		write_reg(CFG_PWM_PERIOD, CFG_DATA_BITS'(period));
		write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_BITS'(debounce));
		write_reg(CFG_DOOR_PHASE_TICKS, CFG_DATA_BITS'(phase));
		write_reg(CFG_WIDTH_RECYCLABLE, CFG_DATA_BITS'(w_r));
		write_reg(CFG_WIDTH_HAZARDOUS, CFG_DATA_BITS'(w_h));
		write_reg(CFG_WIDTH_KITCHEN, CFG_DATA_BITS'(w_k));
		write_reg(CFG_WIDTH_OTHER, CFG_DATA_BITS'(w_o));
	endtask

	// feed quiet ticks until door, debounce and pending byte are all done
	task automatic wait_door_quiet();
		while (p_mode != MODE_IDLE || p_deb_busy || p_pend_v)
			send_tick(tick_of(p_last_raw ? 4'h0 : 4'hF, 1'b0, 8'h00));
	endtask

	// random ticks; guarded traffic never starts a debounce or a door run,
	// so huge counts loaded in the registers are never waited out
	task automatic run_traffic(input int count, input bit guarded, input int pause_at);
		in_item_t it;
		int       roll;
		int       pick;
		for (int k = 0; k < count; k++) begin
			// sender holds off until every output is back
			if (k == pause_at)
				drain();
			roll = $urandom_range(0, 99);
			it.rx_valid = ($urandom_range(0, 99) < 30);
			it.rx_byte  = 8'($urandom_range(0, 255));
			if (guarded) begin
				it.sensor_lines = p_last_raw ? 4'($urandom_range(0, 14)) : 4'hF;
				if (!p_full && (it.rx_byte inside {CHAR_R, CHAR_H, CHAR_K, CHAR_O}))
					it.rx_byte = CHAR_N;
			end else begin
				// mostly held sensor levels, with real changes and short glitches
				if (roll < 8)
					steady_sensors = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
				if (roll >= 8 && roll < 13)
					it.sensor_lines = 4'($urandom_range(0, 15));
				else
					it.sensor_lines = steady_sensors;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					case ($urandom_range(0, 3))
						0:       it.rx_byte = CHAR_R;
						1:       it.rx_byte = CHAR_H;
						2:       it.rx_byte = CHAR_K;
						default: it.rx_byte = CHAR_O;
					endcase
				end else if (pick < 75) begin
					it.rx_byte = $urandom_range(0, 1) ? CHAR_F : CHAR_N;
				end
			end
			send_tick(it);
		end
	endtask

	// reset values: first sample primes a full bin without reporting it,
	// received f, n and unknown bytes are ignored
	task automatic test_reset_defaults();
		send_tick(tick_of(4'h0, 1'b1, CHAR_F));
		send_tick(tick_of(4'h0, 1'b1, CHAR_N));
		send_tick(tick_of(4'h0, 1'b1, 8'hFF));
		send_tick(tick_of(4'h0, 1'b1, 8'h00));
		send_tick(tick_of(4'h0, 1'b0, 8'h00));
	endtask

	// class command opens the door, bytes during the run are latched and
	// the newest one overwrites the older pending byte
	task automatic test_door_cycle();
		send_tick(tick_of(4'h0, 1'b1, CHAR_R));
		send_tick(tick_of(4'h0, 1'b1, 8'h5A));
		send_tick(tick_of(4'h0, 1'b1, CHAR_H));
		wait_door_quiet();
	endtask

	// debounced changes, a rejected glitch, refused commands while full
	task automatic test_debounce_and_full();
		// empty again while not yet reported full: no byte sent
		repeat (3) send_tick(tick_of(4'hF, 1'b0, 8'h00));
		// one-tick glitch is dropped at the end of the window
		send_tick(tick_of(4'hE, 1'b0, 8'h00));
		repeat (3) send_tick(tick_of(4'hF, 1'b0, 8'h00));
		repeat (3) send_tick(tick_of(4'h7, 1'b0, 8'h00));
		send_tick(tick_of(4'h7, 1'b1, CHAR_K));
		send_tick(tick_of(4'hB, 1'b1, CHAR_O));
		repeat (3) send_tick(tick_of(4'hF, 1'b0, 8'h00));
	endtask

	// zero debounce resolves on the tick of the change
	task automatic test_zero_debounce();
		configure(10'd12, 16'd0, 20'd2, 10'd3, 10'd5, 10'd7, 10'd0);
		send_tick(tick_of(4'h0, 1'b0, 8'h00));
		send_tick(tick_of(4'h0, 1'b1, CHAR_R));
		send_tick(tick_of(4'hF, 1'b0, 8'h00));
		send_tick(tick_of(4'hF, 1'b1, CHAR_O));
		wait_door_quiet();
	endtask

	// short frames, windows and phases so every path is crossed often
	task automatic test_random_small(input int count, input int pause_at);
		configure(10'($urandom_range(1, 40)), 16'($urandom_range(0, 6)),
			20'($urandom_range(1, 6)), 10'($urandom_range(0, 45)),
			10'($urandom_range(0, 45)), 10'($urandom_range(0, 45)),
			10'($urandom_range(0, 45)));
		run_traffic(count, 1'b0, pause_at);
	endtask

	// smallest legal period, window and phase, widths at both ends
	task automatic test_random_low_extremes();
		configure(10'd1, 16'd0, 20'd1, $urandom_range(0, 1) ? 10'd1023 : 10'd0,
			$urandom_range(0, 1) ? 10'd1023 : 10'd0, 10'd0, 10'd1023);
		run_traffic(40, 1'b0, -1);
	endtask

	// largest register values, traffic kept away from the long counts
	task automatic test_random_high_extremes();
		wait_door_quiet();
		configure(10'd1023, 16'd65535, 20'd1048575, 10'd1023, 10'd1023, 10'd1023,
			10'd1023);
		run_traffic(30, 1'b1, -1);
	endtask

	// result side: check each output item, then stall a random while
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (predicted_outputs.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					mismatch_count++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("servo_level", 8'(want.servo_level),
						8'(result.servo_level));
					check_field("motor_enable", 8'(want.motor_enable),
						8'(result.motor_enable));
					check_field("dir_open", 8'(want.dir_open), 8'(result.dir_open));
					check_field("dir_close", 8'(want.dir_close), 8'(result.dir_close));
					check_field("tx_valid", 8'(want.tx_valid), 8'(result.tx_valid));
					check_field("tx_byte", want.tx_byte, result.tx_byte);
					check_field("bin_full", 8'(want.bin_full), 8'(result.bin_full));
				end
				hold_cycles = draw_wait();
			end
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles where nothing moves on either side
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("sorting_bin_servo_door_controller regression: fail");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		item_valid     <= 1'b0;
		item           <= '0;
		result_stall   <= 1'b0;
		mismatch_count = 0;
		hold_cycles    = 0;
		calm           = 1'b0;
		steady_sensors = 4'hF;
		reset_predictor();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		test_reset_defaults();
		configure(10'd12, 16'd2, 20'd2, 10'd3, 10'd5, 10'd7, 10'd0);
		test_door_cycle();
		test_debounce_and_full();
		test_zero_debounce();

		// random part, one phase runs with no idling, one has a full pause
		for (int ph = 0; ph < 7; ph++) begin
			calm = (ph == 3);
			test_random_small(55, (ph == 2) ? 20 : -1);
		end
		calm = 1'b0;
		test_random_low_extremes();
		test_random_high_extremes();

		// let the output stage empty and catch any stray result
		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("sorting_bin_servo_door_controller regression: pass");
		else
			$display("sorting_bin_servo_door_controller regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/sbsd_pkg.sv
rtl/sbsd_core.sv
rtl/sorting_bin_servo_door_controller.sv
verif/tb_top.sv
